/* rtl/core/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 16;
   localparam int unsigned MAX_RESULTS     = 16;
   localparam int unsigned CNT_W           = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_REG    = 2'd1;
   localparam logic [1:0] CMD_CANCEL = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [31:0]        delay_frames;
      logic [31:0]        template_id;
      logic [31:0]        scene_id;
      logic [1:0]         object_kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] facing;
      logic [31:0]        spawn_id;
   } req_type;

   typedef struct packed {
      logic [31:0]        template_id;
      logic [31:0]        scene_id;
      logic [1:0]         object_kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] facing;
      logic [31:0]        spawn_id;
   } payload_type;

   typedef struct packed {
      logic               status;
      logic               fired;
      logic [31:0]        out_template;
      logic [31:0]        out_scene;
      logic [1:0]         out_kind;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_facing;
      logic [31:0]        out_spawn_id;
      logic               last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic latch_req;
      logic frame_inc;
      logic tick_clear;
      logic reg_write;
      logic scan_start;
      logic scan_step;
      logic scan_cancel;
      logic remove_best;
      logic emit_held;
      logic emit_empty;
      logic rsp_last;
      logic rsp_status;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       full;
      logic       scan_done;
      logic       best_valid;
      logic       best_enabled;
      logic       held_valid;
      logic       count_full;
      logic       rsp_free;
   } dp_stat_type;

endpackage

/* rtl/core/deq_req_if.sv */
`timescale 1ns / 1ps

interface deq_req_if;
   logic             valid;
   logic             ready;
   deq_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/deq_rsp_if.sv */
`timescale 1ns / 1ps

interface deq_rsp_if;
   logic             valid;
   logic             ready;
   deq_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/deq_ram.sv */
`timescale 1ns / 1ps

module deq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/core/deq_ctrl.sv */
`timescale 1ns / 1ps

module deq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  deq_pkg::dp_stat_type  stat,
   output deq_pkg::ctrl_cmd_type cmd
);
   import deq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_REG    = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_NEXT   = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       fail_ff, fail_in;

   always_comb begin
      state_in  = state_ff;
      fail_in   = fail_ff;
      cmd       = '0;
      req_ready = 1'b0;
      cmd.scan_cancel = (stat.cmd == CMD_CANCEL);
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            fail_in   = 1'b0;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               // req_ff not yet loaded: decode is done in the next state
               state_in = S_REG;
            end
         end
         S_REG: begin
            unique case (stat.cmd)
               CMD_TICK: begin
                  cmd.frame_inc  = 1'b1;
                  cmd.tick_clear = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end
               CMD_REG: begin
                  if (stat.full) begin
                     fail_in = 1'b1;
                  end else begin
                     cmd.reg_write = 1'b1;
                  end
                  state_in = S_DONE;
               end
               CMD_CANCEL: begin
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = (stat.cmd == CMD_CANCEL) ? S_DONE : S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.best_valid) begin
               // held item goes out here only once another enabled item follows it, else in S_EMIT
               if (stat.held_valid && stat.best_enabled) begin
                  if (stat.rsp_free) begin
                     cmd.emit_held = 1'b1;
                  end
               end else begin
                  cmd.remove_best = 1'b1;
                  state_in = S_NEXT;
               end
            end else begin
               state_in = stat.held_valid ? S_EMIT : S_DONE;
            end
         end
         S_NEXT: begin
            if (stat.count_full) begin
               state_in = S_EMIT;
            end else begin
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit_held = 1'b1;
               cmd.rsp_last  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.emit_empty = 1'b1;
               cmd.rsp_last   = 1'b1;
               cmd.rsp_status = fail_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fail_ff  <= fail_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_held |-> stat.held_valid)
      else $error("emit without held item");
   assert property (@(posedge clock) disable iff (reset)
      cmd.remove_best |-> stat.best_valid && !(stat.held_valid && stat.best_enabled))
      else $error("remove without candidate");
   assert property (@(posedge clock) disable iff (reset)
      cmd.reg_write |-> !stat.full)
      else $error("write into full queue");
endmodule

/* rtl/core/deq_datapath.sv */
`timescale 1ns / 1ps

module deq_datapath #(
   parameter int unsigned QUEUE_DEPTH = deq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  deq_pkg::ctrl_cmd_type cmd,
   output deq_pkg::dp_stat_type  stat,
   input  deq_pkg::req_type      req_data,
   output deq_pkg::rsp_type      rsp_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready
);
   import deq_pkg::*;

   localparam int unsigned IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned SCAN_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned PAY_W  = $bits(payload_type);

   req_type              req_ff;
   logic [31:0]          frame_ff;
   logic [SCAN_W-1:0]    arrival_ff;
   logic [QUEUE_DEPTH-1:0] used_ff, enabled_ff;
   logic [IDX_W-1:0]     rank_ff [QUEUE_DEPTH];
   logic [SCAN_W-1:0]    scan_idx_ff;
   logic                 chk_v_ff;
   logic [IDX_W-1:0]     chk_idx_ff;
   logic                 best_v_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [31:0]          best_due_ff;
   logic [IDX_W-1:0]     best_rank_ff;
   logic                 held_ff;
   logic [CNT_W-1:0]     count_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   logic [IDX_W-1:0]     free_idx;
   logic                 issue;
   logic [31:0]          due_rdata;
   logic [PAY_W-1:0]     pay_rdata_raw;
   payload_type          pay_rdata;
   payload_type          pay_wdata;
   logic                 cand;
   logic                 cancel_hit;
   logic                 rsp_free;
   rsp_type              empty_rsp;

   always_comb begin
      free_idx = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign issue = cmd.scan_step && (scan_idx_ff < SCAN_W'(QUEUE_DEPTH));

   assign pay_wdata = '{template_id: req_ff.template_id, scene_id: req_ff.scene_id,
                        object_kind: req_ff.object_kind, pos_x: req_ff.pos_x,
                        pos_y: req_ff.pos_y, pos_z: req_ff.pos_z,
                        facing: req_ff.facing, spawn_id: req_ff.spawn_id};

   deq_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH), .AW(IDX_W)) u_due_ram (
      .clock (clock),
      .we    (cmd.reg_write),
      .waddr (free_idx),
      .wdata (frame_ff + req_ff.delay_frames),
      .re    (issue && !cmd.scan_cancel),
      .raddr (scan_idx_ff[IDX_W-1:0]),
      .rdata (due_rdata)
   );

   // a disabled entry is not read, so the held payload survives its removal
   deq_ram #(.WIDTH(PAY_W), .DEPTH(QUEUE_DEPTH), .AW(IDX_W)) u_pay_ram (
      .clock (clock),
      .we    (cmd.reg_write),
      .waddr (free_idx),
      .wdata (pay_wdata),
      .re    ((issue && cmd.scan_cancel) || (cmd.remove_best && enabled_ff[best_idx_ff])),
      .raddr (cmd.remove_best ? best_idx_ff : scan_idx_ff[IDX_W-1:0]),
      .rdata (pay_rdata_raw)
   );

   assign pay_rdata = payload_type'(pay_rdata_raw);

   // earliest due, then oldest arrival
   assign cand = chk_v_ff && !cmd.scan_cancel && used_ff[chk_idx_ff] &&
                 (due_rdata <= frame_ff) &&
                 (!best_v_ff || (due_rdata < best_due_ff) ||
                  ((due_rdata == best_due_ff) && (rank_ff[chk_idx_ff] < best_rank_ff)));

   assign cancel_hit = chk_v_ff && cmd.scan_cancel && used_ff[chk_idx_ff] &&
                       (pay_rdata.template_id == req_ff.template_id) &&
                       (pay_rdata.scene_id == req_ff.scene_id);

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      empty_rsp        = '0;
      empty_rsp.status = cmd.rsp_status;
      empty_rsp.last   = cmd.rsp_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= '0;
         arrival_ff   <= '0;
         used_ff      <= '0;
         enabled_ff   <= '0;
         scan_idx_ff  <= '0;
         chk_v_ff     <= 1'b0;
         best_v_ff    <= 1'b0;
         held_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.frame_inc) begin
            frame_ff <= frame_ff + 32'd1;
         end
         if (cmd.tick_clear) begin
            held_ff  <= 1'b0;
            count_ff <= '0;
         end
         if (cmd.reg_write) begin
            used_ff[free_idx]    <= 1'b1;
            enabled_ff[free_idx] <= 1'b1;
            arrival_ff           <= arrival_ff + SCAN_W'(1);
         end
         if (cmd.scan_start) begin
            scan_idx_ff <= '0;
            chk_v_ff    <= 1'b0;
            best_v_ff   <= 1'b0;
         end else begin
            if (issue) begin
               scan_idx_ff <= scan_idx_ff + SCAN_W'(1);
            end
            chk_v_ff <= issue;
         end
         if (cand) begin
            best_v_ff <= 1'b1;
         end
         if (cancel_hit) begin
            enabled_ff[chk_idx_ff] <= 1'b0;
         end
         if (cmd.remove_best) begin
            used_ff[best_idx_ff]    <= 1'b0;
            enabled_ff[best_idx_ff] <= 1'b0;
            arrival_ff              <= arrival_ff - SCAN_W'(1);
            best_v_ff               <= 1'b0;
            if (enabled_ff[best_idx_ff]) begin
               held_ff  <= 1'b1;
               count_ff <= count_ff + CNT_W'(1);
            end
         end
         if (cmd.emit_held) begin
            held_ff <= 1'b0;
         end
         if (cmd.emit_held || cmd.emit_empty) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      chk_idx_ff <= scan_idx_ff[IDX_W-1:0];
      if (cand) begin
         best_idx_ff  <= chk_idx_ff;
         best_due_ff  <= due_rdata;
         best_rank_ff <= rank_ff[chk_idx_ff];
      end
      if (cmd.reg_write) begin
         rank_ff[free_idx] <= arrival_ff[IDX_W-1:0];
      end
      if (cmd.remove_best) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (used_ff[i] && (rank_ff[i] > best_rank_ff)) begin
               rank_ff[i] <= rank_ff[i] - IDX_W'(1);
            end
         end
      end
      if (cmd.emit_held) begin
         rsp_ff <= '{status: 1'b0, fired: 1'b1,
                     out_template: pay_rdata.template_id, out_scene: pay_rdata.scene_id,
                     out_kind: pay_rdata.object_kind, out_x: pay_rdata.pos_x,
                     out_y: pay_rdata.pos_y, out_z: pay_rdata.pos_z,
                     out_facing: pay_rdata.facing, out_spawn_id: pay_rdata.spawn_id,
                     last: cmd.rsp_last};
      end else if (cmd.emit_empty) begin
         rsp_ff <= empty_rsp;
      end
   end

   assign stat = '{cmd: req_ff.cmd, full: &used_ff,
                   scan_done: (scan_idx_ff == SCAN_W'(QUEUE_DEPTH)) && !chk_v_ff,
                   best_valid: best_v_ff, best_enabled: enabled_ff[best_idx_ff],
                   held_valid: held_ff,
                   count_full: count_ff == CNT_W'(MAX_RESULTS), rsp_free: rsp_free};

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RESULTS))
      else $error("result count overrun");
   assert property (@(posedge clock) disable iff (reset)
      arrival_ff == SCAN_W'($countones(used_ff)))
      else $error("arrival count out of step with used slots");
   assert property (@(posedge clock) disable iff (reset)
      cmd.remove_best |=> !used_ff[$past(best_idx_ff)])
      else $error("removed slot still in use");
endmodule

/* rtl/core/delayed_event_queue.sv */
`timescale 1ns / 1ps

// Delayed event queue stepped by frame ticks. Each request item is a tick,
// a register or a cancel. A register stores the entry due at frame + delay
// (mod 2^32) and answers status 1 if all QUEUE_DEPTH slots are taken. A
// cancel disables every stored entry whose template and scene match. A tick
// bumps the frame counter and retires every entry with due <= frame, earliest
// due first, ties oldest first, emitting enabled ones (at most 16 per tick,
// the rest wait for later ticks) and dropping disabled ones; the final
// response item of every request carries last, and a tick with nothing to
// fire gives one empty item. One request is handled at a time. A tick finds
// each retired entry by one pass of the due-frame RAM's single read port.
// Response back-pressure only stalls the emit steps.
module delayed_event_queue #(
   parameter int unsigned QUEUE_DEPTH = deq_pkg::QUEUE_DEPTH_DEF
) (
   input logic      clock,
   input logic      reset,
   deq_req_if.sink  req_chan,
   deq_rsp_if.source rsp_chan
);
   import deq_pkg::*;

   ctrl_cmd_type ctl_cmd;
   dp_stat_type  dp_stat;

   // sequencing: decode, scan passes, emit
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (dp_stat),
      .cmd       (ctl_cmd)
   );

   // slot state, due/payload RAMs, response register
   deq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctl_cmd),
      .stat      (dp_stat),
      .req_data  (req_chan.data),
      .rsp_data  (rsp_chan.data),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready)
   );
endmodule
